// ----- rtl/uhr_pkg.sv -----
// Shared constants, types and state encoding for the unit-hydrograph runoff router.
package uhr_pkg;

	localparam int MAX_ORD = 256;
	localparam int ADDR_W = $clog2(MAX_ORD);
	localparam int ADDR_X_W = ADDR_W + 1;
	localparam int CNT_W = $clog2(MAX_ORD + 1);

	localparam int IDX_W = 8;
	localparam int VAL_W = 17;
	localparam int RUN_W = 32;
	localparam int CFGD_W = 9;
	localparam int CFGI_W = 1;

	localparam int SPAN_W = ((CNT_W > CFGD_W) ? CNT_W : CFGD_W) + 1;
	localparam int FRAC_W = 16;
	localparam int ONE_Q16 = 65536;
	localparam int W_W = VAL_W + 1;
	localparam int PROD_W = RUN_W + 1 + W_W;
	localparam int ACC_W = PROD_W + ADDR_W - 1;

	localparam logic REQ_ROUTE = 1'b0;
	localparam logic REQ_LOAD = 1'b1;

	localparam logic [CFGI_W-1:0] CFG_ORD_COUNT = 1'b0;
	localparam logic [CFGI_W-1:0] CFG_STEP_STRIDE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} uhr_state_t;

	typedef struct packed {
		logic curve_we;
		logic [ADDR_W-1:0] curve_waddr;
		logic [VAL_W-1:0] curve_wdata;
		logic [ADDR_W-1:0] curve_raddr;
		logic hist_push;
		logic [RUN_W-1:0] hist_wdata;
		logic hist_advance;
		logic [ADDR_W-1:0] tap_idx;
	} uhr_store_ctl_t;

	typedef struct packed {
		logic clear;
		logic issue;
		logic live;
		logic hi_full;
		logic finish;
	} uhr_mac_ctl_t;

	typedef struct packed {
		logic busy;
		logic out_full;
	} uhr_mac_sts_t;

endpackage

// ----- rtl/uhr_ifs.sv -----
// Handshake interfaces for the request, result and configuration channels.
interface uhr_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [uhr_pkg::IDX_W-1:0] ordinate_index;
	logic [uhr_pkg::VAL_W-1:0] ordinate_value;
	logic [uhr_pkg::RUN_W-1:0] runoff_in;

	modport source(output valid, req_type, ordinate_index, ordinate_value, runoff_in,
		input ready);
	modport sink(input valid, req_type, ordinate_index, ordinate_value, runoff_in,
		output ready);
endinterface

interface uhr_res_if;
	logic valid;
	logic ready;
	logic [uhr_pkg::RUN_W-1:0] routed_runoff;
	logic saturated;

	modport source(output valid, routed_runoff, saturated, input ready);
	modport sink(input valid, routed_runoff, saturated, output ready);
endinterface

interface uhr_cfg_if;
	logic valid;
	logic ready;
	logic [uhr_pkg::CFGI_W-1:0] index;
	logic [uhr_pkg::CFGD_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/uhr_store.sv -----
// Curve table and runoff history ring with its pointer and fill count.
module uhr_store (
	input logic clk,
	input logic arst_n,
	input uhr_pkg::uhr_store_ctl_t ctl,
	output logic [uhr_pkg::VAL_W-1:0] curve_rd_s1,
	output logic [uhr_pkg::RUN_W-1:0] hist_rd_s1,
	output logic [uhr_pkg::CNT_W-1:0] fill
);
	import uhr_pkg::*;

	logic [VAL_W-1:0] curve_mem [MAX_ORD];
	logic [RUN_W-1:0] hist_mem [MAX_ORD];
	logic [ADDR_W-1:0] ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic [ADDR_W-1:0] hist_raddr;

	always_comb begin
		if (ptr_q >= ctl.tap_idx) begin
			hist_raddr = ptr_q - ctl.tap_idx;
		end else begin
			hist_raddr = ADDR_W'(ADDR_X_W'(ptr_q) + ADDR_X_W'(MAX_ORD) - ADDR_X_W'(ctl.tap_idx));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.curve_we) begin
			curve_mem[ctl.curve_waddr] <= ctl.curve_wdata;
		end
		curve_rd_s1 <= curve_mem[ctl.curve_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.hist_push) begin
			hist_mem[ptr_q] <= ctl.hist_wdata;
		end
		hist_rd_s1 <= hist_mem[hist_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctl.hist_push && (fill_q != CNT_W'(MAX_ORD))) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (ctl.hist_advance) begin
				if (ptr_q == ADDR_W'(MAX_ORD - 1)) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_q + ADDR_W'(1);
				end
			end
		end
	end

	assign fill = fill_q;

endmodule

// ----- rtl/uhr_mac.sv -----
// Shared weight, multiply and accumulate unit with the saturating result register.
module uhr_mac (
	input logic clk,
	input logic arst_n,
	input uhr_pkg::uhr_mac_ctl_t ctl,
	input logic [uhr_pkg::VAL_W-1:0] curve_rd_s1,
	input logic [uhr_pkg::RUN_W-1:0] hist_rd_s1,
	uhr_res_if.source res,
	output uhr_pkg::uhr_mac_sts_t sts
);
	import uhr_pkg::*;

	logic v_s1;
	logic v_s2;
	logic live_s1;
	logic full_s1;
	logic out_vld_q;
	logic signed [W_W-1:0] fhi;
	logic signed [W_W-1:0] w;
	logic signed [W_W-1:0] flo_q;
	logic signed [RUN_W:0] sample;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic [RUN_W-1:0] res_d;
	logic sat_d;
	logic [RUN_W-1:0] res_q;
	logic sat_q;

	always_comb begin
		fhi = full_s1 ? W_W'(ONE_Q16) : W_W'(curve_rd_s1);
		w = fhi - flo_q;
		sample = live_s1 ? $signed({1'b0, hist_rd_s1}) : '0;
		prod = sample * w;
	end

	always_comb begin
		if (acc_q[ACC_W-1]) begin
			res_d = '0;
			sat_d = 1'b1;
		end else if (|acc_q[ACC_W-2:RUN_W+FRAC_W]) begin
			res_d = '1;
			sat_d = 1'b1;
		end else begin
			res_d = acc_q[RUN_W+FRAC_W-1:FRAC_W];
			sat_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			if (ctl.finish) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		live_s1 <= ctl.live;
		full_s1 <= ctl.hi_full;
		prod_s2 <= prod;
		if (ctl.clear) begin
			flo_q <= '0;
			acc_q <= '0;
		end else begin
			if (v_s1) begin
				flo_q <= fhi;
			end
			if (v_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
		if (ctl.finish) begin
			res_q <= res_d;
			sat_q <= sat_d;
		end
	end

	assign res.valid = out_vld_q;
	assign res.routed_runoff = res_q;
	assign res.saturated = sat_q;
	assign sts.busy = v_s1 | v_s2;
	assign sts.out_full = out_vld_q & ~res.ready;

endmodule

// ----- rtl/uhr_seq.sv -----
// Sequencer that holds the configuration and steps through the curve taps of one item.
module uhr_seq (
	input logic clk,
	input logic arst_n,
	uhr_req_if.sink req,
	uhr_cfg_if.sink cfg,
	input logic [uhr_pkg::CNT_W-1:0] fill,
	input uhr_pkg::uhr_mac_sts_t mac_sts,
	output uhr_pkg::uhr_store_ctl_t store_ctl,
	output uhr_pkg::uhr_mac_ctl_t mac_ctl
);
	import uhr_pkg::*;

	uhr_state_t state_q;
	uhr_state_t state_d;
	logic [CFGD_W-1:0] ord_count_q;
	logic [CFGD_W-1:0] stride_q;
	logic [CNT_W-1:0] eff_n;
	logic [SPAN_W-1:0] eff_k;
	logic [CNT_W-1:0] j_q;
	logic [SPAN_W-1:0] lo_q;
	logic [SPAN_W-1:0] lo_nxt;
	logic [SPAN_W-1:0] hi;
	logic accept;
	logic route_acc;
	logic load_acc;
	logic last_tap;

	always_comb begin
		if (ord_count_q == '0) begin
			eff_n = CNT_W'(1);
		end else if (SPAN_W'(ord_count_q) > SPAN_W'(MAX_ORD)) begin
			eff_n = CNT_W'(MAX_ORD);
		end else begin
			eff_n = CNT_W'(ord_count_q);
		end
		eff_k = (stride_q == '0) ? SPAN_W'(1) : SPAN_W'(stride_q);
		lo_nxt = lo_q + eff_k;
		hi = (lo_nxt > SPAN_W'(eff_n)) ? SPAN_W'(eff_n) : lo_nxt;
		last_tap = lo_nxt >= SPAN_W'(eff_n);
	end

	assign accept = req.valid & req.ready;
	assign route_acc = accept & (req.req_type == REQ_ROUTE);
	assign load_acc = accept & (req.req_type == REQ_LOAD);
	assign cfg.ready = 1'b1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (route_acc) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (last_tap) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!mac_sts.busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!mac_sts.out_full) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		mac_ctl.issue = 1'b0;
		mac_ctl.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_RUN: mac_ctl.issue = 1'b1;
			ST_DRAIN: ;
			ST_DONE: mac_ctl.finish = ~mac_sts.out_full;
			default: ;
		endcase
		mac_ctl.clear = route_acc;
		mac_ctl.live = j_q < fill;
		mac_ctl.hi_full = hi == SPAN_W'(eff_n);

		store_ctl.curve_we = load_acc && (req.ordinate_index != '0)
			&& (32'(req.ordinate_index) < 32'(MAX_ORD));
		store_ctl.curve_waddr = ADDR_W'(req.ordinate_index);
		store_ctl.curve_wdata = req.ordinate_value;
		store_ctl.curve_raddr = ADDR_W'(hi);
		store_ctl.hist_push = route_acc;
		store_ctl.hist_wdata = req.runoff_in;
		store_ctl.hist_advance = mac_ctl.finish;
		store_ctl.tap_idx = ADDR_W'(j_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q <= '0;
			lo_q <= '0;
		end else begin
			state_q <= state_d;
			if (route_acc) begin
				j_q <= '0;
				lo_q <= '0;
			end else if (state_q == ST_RUN) begin
				j_q <= j_q + CNT_W'(1);
				lo_q <= lo_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ord_count_q <= CFGD_W'(1);
			stride_q <= CFGD_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_ORD_COUNT: ord_count_q <= cfg.data;
				CFG_STEP_STRIDE: stride_q <= cfg.data;
			endcase
		end
	end

	a_route_starts: assert property (@(posedge clk) disable iff (!arst_n)
		route_acc |=> state_q == ST_RUN)
		else $error("A routed item did not start its tap sweep.");

	a_tap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> SPAN_W'(lo_q) < SPAN_W'(eff_n))
		else $error("A tap was issued past the last ordinate.");

	a_finish_empty: assert property (@(posedge clk) disable iff (!arst_n)
		mac_ctl.finish |-> !mac_sts.busy)
		else $error("A result was taken while products were still in flight.");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill) <= 32'(MAX_ORD))
		else $error("The history fill count ran past the ring depth.");

endmodule

// ----- rtl/unit_hydrograph_runoff_router.sv -----
// Top level of the unit-hydrograph runoff router.
// A load item with a nonzero ordinate index writes one curve ordinate and gives no result. A
// runoff item sweeps T = ceil(N / k) taps (N the effective ordinate count, k the effective
// stride), so at most 256 taps with 256 ordinates and a stride of one. One multiply-accumulate
// unit is shared by all taps and handles one tap per cycle, reading one history word and one
// curve point per tap; after the last tap the item passes the read and product registers and
// the result hand-off, which waits while the previous result is not taken, before the next
// item can be accepted. The result waits in an output register, and history is cleared at
// reset through a fill count, so no clearing pass follows reset.
module unit_hydrograph_runoff_router (
	input logic clk,
	input logic arst_n,
	uhr_req_if.sink req,
	uhr_res_if.source res,
	uhr_cfg_if.sink cfg
);
	import uhr_pkg::*;

	uhr_store_ctl_t store_ctl;
	uhr_mac_ctl_t mac_ctl;
	uhr_mac_sts_t mac_sts;
	logic [VAL_W-1:0] curve_rd_s1;
	logic [RUN_W-1:0] hist_rd_s1;
	logic [CNT_W-1:0] fill;

	uhr_store u_store (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(store_ctl),
		.curve_rd_s1(curve_rd_s1),
		.hist_rd_s1(hist_rd_s1),
		.fill(fill)
	);

	uhr_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(mac_ctl),
		.curve_rd_s1(curve_rd_s1),
		.hist_rd_s1(hist_rd_s1),
		.res(res),
		.sts(mac_sts)
	);

	uhr_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cfg(cfg),
		.fill(fill),
		.mac_sts(mac_sts),
		.store_ctl(store_ctl),
		.mac_ctl(mac_ctl)
	);

endmodule
